// ===== rtl/mcg_pkg.sv =====
// mcg_pkg: shared types, constants and calendar helper functions for the
// month calendar grid unit. No dependencies.
package mcg_pkg;

  localparam int unsigned GridCells = 42;
  localparam logic [5:0]  LastCell  = 6'(GridCells - 1);

  // reciprocal constants for division by 12, 25 and 7
  localparam logic [9:0]  Div12Mul = 10'd683;
  localparam int unsigned Div12Sh  = 13;
  localparam logic [12:0] Div25Mul = 13'd5243;
  localparam int unsigned Div25Sh  = 17;
  localparam logic [15:0] Mod7Mul  = 16'd37450;
  localparam int unsigned Mod7Sh   = 18;

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_SHIFT = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [13:0]       year;
    logic [7:0]        month;
    logic signed [7:0] delta;
    logic [4:0]        today;
  } req_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  today;
  } nrm_t;

  typedef struct packed {
    logic [14:0] wd_sum;
    logic [4:0]  days;
    logic [4:0]  prev_days;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  today;
  } cal_t;

  typedef struct packed {
    logic [2:0]  first_wd;
    logic [4:0]  days;
    logic [4:0]  prev_days;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  today;
  } grid_t;

  // exact for t up to 525
  function automatic logic [5:0] div12(input logic [9:0] t);
    logic [19:0] p;
    p = 20'(t) * 20'(Div12Mul);
    return p[Div12Sh +: 6];
  endfunction

  // exact for x up to 16383
  function automatic logic [9:0] div25(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(Div25Mul);
    return p[Div25Sh +: 10];
  endfunction

  // exact for s up to about 30000
  function automatic logic [2:0] mod7(input logic [14:0] s);
    logic [30:0] p;
    logic [14:0] q;
    logic [14:0] r;
    p = 31'(s) * 31'(Mod7Mul);
    q = 15'(p[Mod7Sh +: 13]);
    r = s - q * 15'd7;
    return r[2:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_offs(input logic [3:0] m);
    logic [2:0] offs;
    unique case (m)
      4'd1:    offs = 3'd0;
      4'd2:    offs = 3'd3;
      4'd3:    offs = 3'd2;
      4'd4:    offs = 3'd5;
      4'd5:    offs = 3'd0;
      4'd6:    offs = 3'd3;
      4'd7:    offs = 3'd5;
      4'd8:    offs = 3'd1;
      4'd9:    offs = 3'd4;
      4'd10:   offs = 3'd6;
      4'd11:   offs = 3'd2;
      4'd12:   offs = 3'd4;
      default: offs = 3'd0;
    endcase
    return offs;
  endfunction

endpackage

// ===== rtl/month_calendar_grid_unit.sv =====
// month_calendar_grid_unit: top level of the six-week month calendar grid.
// Path: input, normalization, calendar, grid and cell output registers in turn.
// Throughput: one cell per cycle at the result port while out_ready_i is high;
// up to four items are held in the pipeline while a grid is being sent.
// Reset: asynchronous, active low; all stages empty, no result valid.
// Depends on mcg_pkg, mcg_norm, mcg_cal and mcg_emit.
module month_calendar_grid_unit import mcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [13:0] year_i,
  input  logic [7:0]  month_i,
  input  logic signed [7:0] delta_months_i,
  input  logic [4:0]  today_day_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  cell_index_o,
  output logic [4:0]  day_number_o,
  output logic        in_month_o,
  output logic        is_today_o,
  output logic [2:0]  start_wday_o,
  output logic [4:0]  num_days_o,
  output logic [13:0] shown_year_o,
  output logic [3:0]  shown_month_o,
  output logic        last_cell_o
);

  req_t req;
  nrm_t nrm;
  cal_t cal;
  logic nrm_valid;
  logic nrm_ready;
  logic cal_valid;
  logic cal_ready;

  always_comb begin
    req.op    = op_e'(opcode_i);
    req.year  = year_i;
    req.month = month_i;
    req.delta = delta_months_i;
    req.today = today_day_i;
  end

  mcg_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req),
    .out_valid_o (nrm_valid),
    .out_ready_i (nrm_ready),
    .nrm_o       (nrm)
  );

  mcg_cal u_cal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (nrm_valid),
    .in_ready_o  (nrm_ready),
    .nrm_i       (nrm),
    .out_valid_o (cal_valid),
    .out_ready_i (cal_ready),
    .cal_o       (cal)
  );

  mcg_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (cal_valid),
    .in_ready_o    (cal_ready),
    .cal_i         (cal),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_index_o  (cell_index_o),
    .day_number_o  (day_number_o),
    .in_month_o    (in_month_o),
    .is_today_o    (is_today_o),
    .start_wday_o  (start_wday_o),
    .num_days_o    (num_days_o),
    .shown_year_o  (shown_year_o),
    .shown_month_o (shown_month_o),
    .last_cell_o   (last_cell_o)
  );

endmodule

// ===== rtl/mcg_norm.sv =====
// mcg_norm: input register and month normalization stage (clamp or shift
// with year carry). Depends on mcg_pkg.
module mcg_norm import mcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output nrm_t nrm_o
);

  logic a_valid_q;
  req_t req_q;
  logic b_valid_q;
  nrm_t nrm_q;
  nrm_t nrm_d;
  logic b_ready;

  logic [9:0]  t;
  logic [5:0]  q;
  logic [9:0]  r;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || b_ready;

  always_comb begin
    t = 10'(req_q.month) + {{2{req_q.delta[7]}}, req_q.delta} + 10'd143;
    q = div12(t);
    r = t - 10'(q) * 10'd12;
    nrm_d = '0;
    if (req_q.op == OP_BUILD) begin
      nrm_d.year  = req_q.year;
      nrm_d.today = req_q.today;
      if (req_q.month == 8'd0) begin
        nrm_d.month = 4'd1;
      end else if (req_q.month > 8'd12) begin
        nrm_d.month = 4'd12;
      end else begin
        nrm_d.month = req_q.month[3:0];
      end
    end else begin
      nrm_d.year  = req_q.year + 14'(q) - 14'd12;
      nrm_d.month = r[3:0] + 4'd1;
      nrm_d.today = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      a_valid_q <= 1'b1;
    end else if (b_ready) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      nrm_q <= nrm_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign nrm_o       = nrm_q;

endmodule

// ===== rtl/mcg_cal.sv =====
// mcg_cal: leap year, month lengths and weekday sum stage.
// Depends on mcg_pkg.
module mcg_cal import mcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  nrm_t nrm_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cal_t cal_o
);

  logic valid_q;
  cal_t cal_q;
  cal_t cal_d;

  logic [14:0] yy;
  logic [12:0] yq4;
  logic [9:0]  yq100;
  logic [9:0]  y_div25;
  logic [13:0] y_mod25;
  logic        leap;
  logic [3:0]  prev_m;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    yy      = 15'(nrm_i.year) + 15'd400 - ((nrm_i.month < 4'd3) ? 15'd1 : 15'd0);
    yq4     = yy[14:2];
    yq100   = div25(14'(yq4));
    y_div25 = div25(nrm_i.year);
    y_mod25 = nrm_i.year - 14'(y_div25) * 14'd25;
    leap    = (nrm_i.year[1:0] == 2'd0) &&
              ((y_mod25 != 14'd0) || (nrm_i.year[3:0] == 4'd0));
    prev_m  = (nrm_i.month == 4'd1) ? 4'd12 : nrm_i.month - 4'd1;

    cal_d.wd_sum    = yy + 15'(yq4) - 15'(yq100) + 15'(yq100[9:2])
                      + 15'(month_offs(nrm_i.month)) + 15'd1;
    cal_d.days      = month_len(nrm_i.month, leap);
    cal_d.prev_days = month_len(prev_m, leap);
    cal_d.year      = nrm_i.year;
    cal_d.month     = nrm_i.month;
    cal_d.today     = nrm_i.today;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cal_q <= cal_d;
    end
  end

  assign out_valid_o = valid_q;
  assign cal_o       = cal_q;

endmodule

// ===== rtl/mcg_emit.sv =====
// mcg_emit: grid descriptor register, cell counter and output register that
// sends the 42 cells of one grid. Depends on mcg_pkg.
module mcg_emit import mcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cal_t        cal_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  cell_index_o,
  output logic [4:0]  day_number_o,
  output logic        in_month_o,
  output logic        is_today_o,
  output logic [2:0]  start_wday_o,
  output logic [4:0]  num_days_o,
  output logic [13:0] shown_year_o,
  output logic [3:0]  shown_month_o,
  output logic        last_cell_o
);

  logic       grid_valid_q;
  grid_t      grid_q;
  grid_t      grid_d;
  logic [5:0] cnt_q;
  logic       issue;
  logic       last_issue;

  logic       out_valid_q;
  logic [5:0] cell_index_q;
  logic [4:0] day_q;
  logic       inm_q;
  logic       tod_q;
  logic [2:0] fw_q;
  logic [4:0] days_q;
  logic [13:0] year_q;
  logic [3:0] month_q;
  logic       last_q;

  logic [5:0] fw6;
  logic [5:0] cur;
  logic [5:0] day6;
  logic       inm;
  logic       tod;

  assign issue      = grid_valid_q && (!out_valid_q || out_ready_i);
  assign last_issue = issue && (cnt_q == LastCell);
  assign in_ready_o = !grid_valid_q || last_issue;

  always_comb begin
    grid_d.first_wd  = mod7(cal_i.wd_sum);
    grid_d.days      = cal_i.days;
    grid_d.prev_days = cal_i.prev_days;
    grid_d.year      = cal_i.year;
    grid_d.month     = cal_i.month;
    grid_d.today     = cal_i.today;
  end

  // cell contents for the current counter value
  always_comb begin
    fw6  = 6'(grid_q.first_wd);
    cur  = cnt_q - fw6 + 6'd1;
    inm  = 1'b0;
    tod  = 1'b0;
    if (cnt_q < fw6) begin
      day6 = 6'(grid_q.prev_days) + cnt_q + 6'd1 - fw6;
    end else if (cur <= 6'(grid_q.days)) begin
      day6 = cur;
      inm  = 1'b1;
      tod  = (grid_q.today != 5'd0) && (cur == 6'(grid_q.today));
    end else begin
      day6 = cur - 6'(grid_q.days);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        grid_valid_q <= 1'b1;
      end else if (last_issue) begin
        grid_valid_q <= 1'b0;
      end
      if (issue) begin
        cnt_q       <= last_issue ? 6'd0 : cnt_q + 6'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      grid_q <= grid_d;
    end
    if (issue) begin
      cell_index_q <= cnt_q;
      day_q        <= day6[4:0];
      inm_q        <= inm;
      tod_q        <= tod;
      fw_q         <= grid_q.first_wd;
      days_q       <= grid_q.days;
      year_q       <= grid_q.year;
      month_q      <= grid_q.month;
      last_q       <= (cnt_q == LastCell);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_index_o  = cell_index_q;
  assign day_number_o  = day_q;
  assign in_month_o    = inm_q;
  assign is_today_o    = tod_q;
  assign start_wday_o  = fw_q;
  assign num_days_o    = days_q;
  assign shown_year_o  = year_q;
  assign shown_month_o = month_q;
  assign last_cell_o   = last_q;

`ifndef ASSERT_OFF
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_cell_o == (cell_index_o == LastCell)))
    else $error("last cell flag does not match cell index");

  a_cell_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_cell_o) |=>
      (out_valid_o && (cell_index_o == $past(cell_index_o) + 6'd1)))
    else $error("grid cells not sent in consecutive order");

  a_grid_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_cell_o) |=>
      ($stable(shown_year_o) && $stable(shown_month_o) && $stable(start_wday_o)))
    else $error("grid description changed within one grid");

  a_today_in_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_today_o) |-> in_month_o)
    else $error("today mark outside the displayed month");
`endif

endmodule

// ===== verif/month_calendar_grid_unit_tb.sv =====
`timescale 1ns / 1ps
// month_calendar_grid_unit_tb: self-checking bench for the month grid unit, predicts
// all 42 cells of every request and compares them field by field as they leave.
// Depends on mcg_pkg and month_calendar_grid_unit.
module month_calendar_grid_unit_tb;
  import mcg_pkg::*;

  localparam int DrainCycles = 12;
  localparam int StallCycles = 400;
  localparam int YearWrap    = 16384;
  localparam int MonthDays [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int FirstDayOffs [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam int YearCorners [7]  = '{0, 1, 1969, 1970, 9999, 10000, 16383};

  typedef struct {
    logic [5:0]  idx;
    logic [4:0]  day;
    logic        in_month;
    logic        today;
    logic [2:0]  first_wd;
    logic [4:0]  days;
    logic [13:0] year;
    logic [3:0]  month;
    logic        last;
  } grid_cell_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  op_e               opcode = OP_BUILD;
  logic [13:0]       year = '0;
  logic [7:0]        month = '0;
  logic signed [7:0] delta = '0;
  logic [4:0]        today = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [5:0]        cell_index;
  logic [4:0]        day_number;
  logic              in_month;
  logic              is_today;
  logic [2:0]        start_wday;
  logic [4:0]        num_days;
  logic [13:0]       shown_year;
  logic [3:0]        shown_month;
  logic              last_cell;

  grid_cell_t grid_cells_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic stall_rx = 1'b0;
  int mismatch_cnt = 0;
  int cells_checked = 0;
  int build_cnt = 0;
  int shift_cnt = 0;
  int marked_cnt = 0;

  month_calendar_grid_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .year_i         (year),
    .month_i        (month),
    .delta_months_i (delta),
    .today_day_i    (today),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .cell_index_o   (cell_index),
    .day_number_o   (day_number),
    .in_month_o     (in_month),
    .is_today_o     (is_today),
    .start_wday_o   (start_wday),
    .num_days_o     (num_days),
    .shown_year_o   (shown_year),
    .shown_month_o  (shown_month),
    .last_cell_o    (last_cell)
  );

  always #5 clk = ~clk;

  function automatic bit leap_year(int y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int month_length(int y, int m);
    if (m == 2 && leap_year(y)) return 29;
    return MonthDays[m - 1];
  endfunction

  function automatic int first_day_of_week(int y, int m);
    int yy;
    yy = y + 400 - ((m < 3) ? 1 : 0);
    return (yy + yy / 4 - yy / 100 + yy / 400 + FirstDayOffs[m - 1] + 1) % 7;
  endfunction

  // queue the 42 cells that one request should produce
  function automatic void predict_grid(op_e op, int y, int m, int d, int td);
    int yr, mo, t, fw, nd, pd, mark, cur;
    grid_cell_t c;
    if (op == OP_BUILD) begin
      yr = y;
      mo = (m < 1) ? 1 : (m > 12) ? 12 : m;
      mark = td;
    end else begin
      t = m + d + 143;
      yr = (y + t / 12 + YearWrap - 12) % YearWrap;
      mo = t % 12 + 1;
      mark = 0;
    end
    fw = first_day_of_week(yr, mo);
    nd = month_length(yr, mo);
    pd = month_length(yr, (mo == 1) ? 12 : mo - 1);
    for (int i = 0; i < GridCells; i++) begin
      c.idx = 6'(i);
      c.in_month = 1'b0;
      c.today = 1'b0;
      if (i < fw) begin
        c.day = 5'(pd - (fw - i) + 1);
      end else begin
        cur = i - fw + 1;
        if (cur <= nd) begin
          c.day = 5'(cur);
          c.in_month = 1'b1;
          c.today = (mark != 0 && cur == mark);
        end else begin
          c.day = 5'(cur - nd);
        end
      end
      if (c.today) marked_cnt++;
      c.first_wd = 3'(fw);
      c.days = 5'(nd);
      c.year = 14'(yr);
      c.month = 4'(mo);
      c.last = (i == GridCells - 1);
      grid_cells_q.push_back(c);
    end
  endfunction

  task automatic send_request(op_e op, logic [13:0] y, logic [7:0] m,
                              logic signed [7:0] d, logic [4:0] td);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    year <= y;
    month <= m;
    delta <= d;
    today <= td;
    do @(posedge clk); while (!in_ready);
    predict_grid(op, y, m, d, td);
    if (op == OP_BUILD) build_cnt++;
    else shift_cnt++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (grid_cells_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_idling(int tx_pct, int rx_pct);
    send_idle_pct = tx_pct;
    recv_idle_pct <= rx_pct;
  endtask

  function automatic logic [13:0] rand_year();
    case ($urandom_range(9))
      0, 1:    return 14'($urandom_range(YearWrap - 1));
      2:       return 14'(YearCorners[$urandom_range(6)]);
      default: return 14'($urandom_range(1, 9999));
    endcase
  endfunction

  // clamping, leap rules, today mark limits and grid shapes
  task automatic test_build_corners();
    send_request(OP_BUILD, 14'd2024, 8'd2, 8'sd0, 5'd29);
    send_request(OP_BUILD, 14'd1900, 8'd2, 8'sd0, 5'd29);
    send_request(OP_BUILD, 14'd2000, 8'd2, 8'sd0, 5'd31);
    send_request(OP_BUILD, 14'd0, 8'd0, 8'sd0, 5'd1);
    send_request(OP_BUILD, 14'd16383, 8'd255, 8'sd127, 5'd31);
    send_request(OP_BUILD, 14'd9999, 8'd13, 8'sd0, 5'd0);
    send_request(OP_BUILD, 14'd1, 8'd1, -8'sd128, 5'd15);
    send_request(OP_BUILD, 14'd1969, 8'd12, 8'sd0, 5'd31);
    send_request(OP_BUILD, 14'd2023, 8'd4, 8'sd0, 5'd30);
    send_request(OP_BUILD, 14'd2024, 8'd9, 8'sd0, 5'd1);
    send_request(OP_BUILD, 14'd2024, 8'd6, 8'sd0, 5'd30);
    send_request(OP_BUILD, 14'd2015, 8'd2, 8'sd0, 5'd28);
    send_request(OP_BUILD, 14'd2022, 8'd10, 8'sd0, 5'd31);
  endtask

  // month carry into the year and year wrap at 14 bits
  task automatic test_shift_carry();
    send_request(OP_SHIFT, 14'd2024, 8'd1, -8'sd1, 5'd0);
    send_request(OP_SHIFT, 14'd2024, 8'd12, 8'sd1, 5'd0);
    send_request(OP_SHIFT, 14'd0, 8'd1, -8'sd128, 5'd0);
    send_request(OP_SHIFT, 14'd16383, 8'd255, 8'sd127, 5'd31);
    send_request(OP_SHIFT, 14'd100, 8'd0, 8'sd0, 5'd0);
    send_request(OP_SHIFT, 14'd5, 8'd255, -8'sd128, 5'd7);
    send_request(OP_SHIFT, 14'd2024, 8'd3, 8'sd0, 5'd5);
    send_request(OP_SHIFT, 14'd9999, 8'd12, 8'sd1, 5'd0);
    send_request(OP_SHIFT, 14'd0, 8'd0, 8'sd0, 5'd0);
    wait_drained();
  endtask

  task automatic test_random_requests(int n);
    op_e op;
    logic [7:0] m;
    for (int k = 0; k < n; k++) begin
      op = $urandom_range(1) ? OP_SHIFT : OP_BUILD;
      if ($urandom_range(9) < 7) m = 8'($urandom_range(1, 12));
      else m = 8'($urandom_range(255));
      send_request(op, rand_year(), m, 8'($urandom_range(255)), 5'($urandom_range(31)));
    end
    wait_drained();
  endtask

  // receiver holds off long enough for the unit to fill and stop taking items
  task automatic test_receiver_stall();
    stall_rx <= 1'b1;
    fork
      begin
        repeat (StallCycles) @(posedge clk);
        stall_rx <= 1'b0;
      end
    join_none
    test_random_requests(8);
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !stall_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s expected %0d got %0d", name, exp_val, act_val);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin : cell_check
    grid_cell_t c;
    if (rst_n && out_valid && out_ready) begin
      if (grid_cells_q.size() == 0) begin
        $error("cell %0d arrived with no grid outstanding", cell_index);
        mismatch_cnt++;
      end else begin
        c = grid_cells_q.pop_front();
        check_field("cell_index", c.idx, cell_index);
        check_field("day_number", c.day, day_number);
        check_field("in_month", c.in_month, in_month);
        check_field("is_today", c.today, is_today);
        check_field("start_wday", c.first_wd, start_wday);
        check_field("num_days", c.days, num_days);
        check_field("shown_year", c.year, shown_year);
        check_field("shown_month", c.month, shown_month);
        check_field("last_cell", c.last, last_cell);
        cells_checked++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(18, 73);
    test_build_corners();
    test_shift_carry();
    test_random_requests(60);
    set_idling(73, 18);
    test_random_requests(60);
    set_idling(0, 0);
    test_random_requests(50);
    test_receiver_stall();
    $display("%0d requests (%0d build, %0d shift), %0d cells compared, %0d today marks",
             build_cnt + shift_cnt, build_cnt, shift_cnt, cells_checked, marked_cnt);
    $display("idle mixes on both sides plus one %0d-cycle receiver hold-off", StallCycles);
    if (mismatch_cnt == 0 && grid_cells_q.size() == 0) begin
      $display("month_calendar_grid_unit_tb OK");
    end else begin
      $display("month_calendar_grid_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("month_calendar_grid_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mcg_pkg.sv
rtl/mcg_norm.sv
rtl/mcg_cal.sv
rtl/mcg_emit.sv
rtl/month_calendar_grid_unit.sv
verif/month_calendar_grid_unit_tb.sv
